>>> rtl/lrt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lrt_pkg
// Shared types, codes, sizes and the sigmoid table for the trainer.
// ----------------------------------------------------------------------------
package lrt_pkg;

  localparam int MaxFeatures     = 16;
  localparam int MaxObservations = 256;
  localparam int SigDepth        = 256;

  localparam int FEAT_W   = $clog2(MaxFeatures);
  localparam int OBS_W    = $clog2(MaxObservations);
  localparam int FADDR_W  = OBS_W + FEAT_W;
  localparam int SIG_W    = $clog2(SigDepth);
  localparam int SigSpanShift = 20;
  localparam int SIG_IDX_SHIFT = SigSpanShift - SIG_W;
  localparam int SigOffset = 524288;
  localparam int ERR_W    = 18;
  localparam int DivSteps = 64;
  localparam int DCNT_W   = $clog2(DivSteps + 1);
  localparam int PADDR_W  = 5;

  typedef enum logic [1:0] {
    CMD_LOAD_WEIGHT  = 2'd0,
    CMD_LOAD_FEATURE = 2'd1,
    CMD_LOAD_LABEL   = 2'd2,
    CMD_START        = 2'd3
  } cmd_code_t;

  typedef enum logic [2:0] {
    REG_FEATURE_COUNT = 3'd0,
    REG_OBS_COUNT     = 3'd1,
    REG_LEARNING_RATE = 3'd2,
    REG_TOLERANCE     = 3'd3,
    REG_ITER_LIMIT    = 3'd4
  } reg_index_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_STEP, ST_A_RUN, ST_A_DRAIN, ST_B_RUN, ST_B_DRAIN,
    ST_DIV_GO, ST_DIV_WAIT, ST_SIGN, ST_MUL_LO, ST_MUL_HI, ST_DELTA,
    ST_UPDATE, ST_CHECK, ST_COMMIT, ST_EMIT_LOAD, ST_EMIT_SHOW
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_CLEAR, OP_DIV, OP_SIGN, OP_MUL_LO, OP_MUL_HI,
    OP_DELTA, OP_UPDATE, OP_CHECK, OP_COMMIT
  } dp_op_t;

  typedef struct packed {
    logic [4:0]  n_eff;
    logic [8:0]  m_eff;
    logic [15:0] lr;
    logic [15:0] tol;
    logic [15:0] limit;
  } cfg_t;

  typedef struct packed {
    logic             issue;
    logic             phase_b;
    logic             first;
    logic             last;
    logic [OBS_W-1:0] obs;
    logic [FEAT_W-1:0] feat;
    dp_op_t           op;
    logic             ld_en;
  } ctrl_cmd_t;

  typedef struct packed {
    logic busy;
    logic div_busy;
    logic small_ok;
  } dp_stat_t;

  typedef logic [16:0] sig_table_t [SigDepth];

  // sigmoid of a nonnegative Q16.16 value, Q16 result; elaboration only
  function automatic logic [16:0] sig_pos(input logic [31:0] a);
    logic [127:0] u;
    logic [63:0]  den;
    logic [63:0]  num;
    logic [63:0]  q;
    logic [64:0]  r;
    if (a == 32'd0) begin
      u = 128'd1 << 32;
    end else begin
      u = (128'd1 << 32) - {96'd0, a};
      for (int k = 0; k < 16; k++) u = (u * u) >> 32;
    end
    den = (64'd1 << 32) + u[63:0];
    num = (64'd1 << 48) + (den >> 1);
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], num[b]};
      if (r >= {1'b0, den}) begin
        r = r - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    return q[16:0];
  endfunction

  function automatic sig_table_t build_sig_table();
    sig_table_t t;
    longint z;
    for (int k = 0; k < SigDepth; k++) begin
      z = longint'(k) * longint'((1 << SigSpanShift) / SigDepth) - longint'(SigOffset);
      if (z >= 0) t[k] = sig_pos(32'(z));
      else        t[k] = 17'd65536 - sig_pos(32'(-z));
    end
    return t;
  endfunction

  localparam sig_table_t SIG_TABLE = build_sig_table();

endpackage
`default_nettype wire

>>> rtl/lrt_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lrt_if
// Input and output item channels of the trainer.
// ----------------------------------------------------------------------------
interface lrt_in_if;
  import lrt_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        cmd;
  logic [7:0]        obs_index;
  logic [3:0]        feature_index;
  logic signed [31:0] value;
  modport source (output valid, cmd, obs_index, feature_index, value, input ready);
  modport sink   (input valid, cmd, obs_index, feature_index, value, output ready);
endinterface

interface lrt_out_if;
  import lrt_pkg::*;
  logic              valid;
  logic              ready;
  logic [3:0]        weight_index;
  logic signed [31:0] weight_value;
  logic              converged;
  logic [15:0]       iterations_used;
  logic              last;
  modport source (output valid, weight_index, weight_value, converged, iterations_used,
                  last, input ready);
  modport sink   (input valid, weight_index, weight_value, converged, iterations_used,
                  last, output ready);
endinterface
`default_nettype wire

>>> rtl/lrt_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lrt_regs
// APB register file; presents the clamped counts to the rest of the block.
// ----------------------------------------------------------------------------
module lrt_regs (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [lrt_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  output lrt_pkg::cfg_t                    cfg
);
  import lrt_pkg::*;

  logic [4:0]  feature_count;
  logic [8:0]  observation_count;
  logic [15:0] learning_rate;
  logic [15:0] tolerance;
  logic [15:0] iteration_limit;
  logic        wr;
  reg_index_t  idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = reg_index_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      feature_count     <= 5'd16;
      observation_count <= 9'd256;
      learning_rate     <= 16'd655;
      tolerance         <= 16'd66;
      iteration_limit   <= 16'd1000;
    end else if (wr) begin
      case (idx)
        REG_FEATURE_COUNT: feature_count     <= pwdata[4:0];
        REG_OBS_COUNT:     observation_count <= pwdata[8:0];
        REG_LEARNING_RATE: learning_rate     <= pwdata[15:0];
        REG_TOLERANCE:     tolerance         <= pwdata[15:0];
        REG_ITER_LIMIT:    iteration_limit   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_FEATURE_COUNT: prdata = {27'd0, feature_count};
      REG_OBS_COUNT:     prdata = {23'd0, observation_count};
      REG_LEARNING_RATE: prdata = {16'd0, learning_rate};
      REG_TOLERANCE:     prdata = {16'd0, tolerance};
      REG_ITER_LIMIT:    prdata = {16'd0, iteration_limit};
      default:           prdata = 32'd0;
    endcase
  end

  always_comb begin
    if (feature_count == 5'd0)                     cfg.n_eff = 5'd1;
    else if (feature_count > 5'(MaxFeatures))      cfg.n_eff = 5'(MaxFeatures);
    else                                           cfg.n_eff = feature_count;
    if (observation_count == 9'd0)                 cfg.m_eff = 9'd1;
    else if (observation_count > 9'(MaxObservations)) cfg.m_eff = 9'(MaxObservations);
    else                                           cfg.m_eff = observation_count;
    cfg.lr    = learning_rate;
    cfg.tol   = tolerance;
    cfg.limit = iteration_limit;
  end

endmodule
`default_nettype wire

>>> rtl/lrt_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lrt_ctrl
// Sequencer: walks observations and features, runs the weight update steps
// and hands out the trained weights.
// ----------------------------------------------------------------------------
module lrt_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire lrt_pkg::cfg_t     cfg,
  input  wire logic              in_valid,
  input  wire logic [1:0]        in_cmd,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [3:0]             out_index,
  output logic                   out_conv,
  output logic [15:0]            out_iters,
  output logic                   out_last,
  output lrt_pkg::ctrl_cmd_t     cmd,
  input  wire lrt_pkg::dp_stat_t stat
);
  import lrt_pkg::*;

  state_t            state;
  state_t            state_next;
  logic [OBS_W-1:0]  i;
  logic [FEAT_W-1:0] j;
  logic [15:0]       cnt;
  logic              conv;
  logic              i_last;
  logic              j_last;
  logic              accept;
  logic              start;
  logic              done;

  assign i_last = ({1'b0, i} == cfg.m_eff - 9'd1);
  assign j_last = ({1'b0, j} == cfg.n_eff - 5'd1);
  assign accept = in_valid && in_ready;
  assign start  = accept && (cmd_code_t'(in_cmd) == CMD_START);
  assign done   = stat.small_ok || ({1'b0, cnt} + 17'd1 >= {1'b0, cfg.limit});

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:      if (start) state_next = (cfg.limit == 16'd0) ? ST_EMIT_LOAD : ST_STEP;
      ST_STEP:      state_next = ST_A_RUN;
      ST_A_RUN:     if (i_last && j_last) state_next = ST_A_DRAIN;
      ST_A_DRAIN:   if (!stat.busy) state_next = ST_B_RUN;
      ST_B_RUN:     if (i_last) state_next = ST_B_DRAIN;
      ST_B_DRAIN:   if (!stat.busy) state_next = ST_DIV_GO;
      ST_DIV_GO:    state_next = ST_DIV_WAIT;
      ST_DIV_WAIT:  if (!stat.div_busy) state_next = ST_SIGN;
      ST_SIGN:      state_next = ST_MUL_LO;
      ST_MUL_LO:    state_next = ST_MUL_HI;
      ST_MUL_HI:    state_next = ST_DELTA;
      ST_DELTA:     state_next = ST_UPDATE;
      ST_UPDATE:    state_next = ST_CHECK;
      ST_CHECK:     state_next = j_last ? ST_COMMIT : ST_B_RUN;
      ST_COMMIT:    state_next = done ? ST_EMIT_LOAD : ST_STEP;
      ST_EMIT_LOAD: state_next = ST_EMIT_SHOW;
      ST_EMIT_SHOW: if (out_ready) state_next = j_last ? ST_IDLE : ST_EMIT_LOAD;
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.op      = OP_NONE;
    cmd.obs     = i;
    cmd.feat    = j;
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.ld_en = accept && (cmd_code_t'(in_cmd) != CMD_START);
      end
      ST_STEP: cmd.op = OP_CLEAR;
      ST_A_RUN: begin
        cmd.issue = 1'b1;
        cmd.first = (j == '0);
        cmd.last  = j_last;
      end
      ST_B_RUN: begin
        cmd.issue   = 1'b1;
        cmd.phase_b = 1'b1;
        cmd.first   = (i == '0);
        cmd.last    = i_last;
      end
      ST_DIV_GO:    cmd.op = OP_DIV;
      ST_SIGN:      cmd.op = OP_SIGN;
      ST_MUL_LO:    cmd.op = OP_MUL_LO;
      ST_MUL_HI:    cmd.op = OP_MUL_HI;
      ST_DELTA:     cmd.op = OP_DELTA;
      ST_UPDATE:    cmd.op = OP_UPDATE;
      ST_CHECK:     cmd.op = OP_CHECK;
      ST_COMMIT:    cmd.op = OP_COMMIT;
      ST_EMIT_SHOW: out_valid = 1'b1;
      default: ;
    endcase
  end

  assign out_index = j;
  assign out_conv  = conv;
  assign out_iters = cnt;
  assign out_last  = j_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      i     <= '0;
      j     <= '0;
      cnt   <= '0;
      conv  <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: if (start) begin
          cnt  <= '0;
          conv <= 1'b0;
          i    <= '0;
          j    <= '0;
        end
        ST_STEP: begin
          i <= '0;
          j <= '0;
        end
        ST_A_RUN: begin
          if (j_last) begin
            j <= '0;
            i <= i + 1'b1;
          end else begin
            j <= j + 1'b1;
          end
        end
        ST_A_DRAIN: i <= '0;
        ST_B_RUN:   i <= i_last ? '0 : i + 1'b1;
        ST_CHECK:   if (!j_last) j <= j + 1'b1;
        ST_COMMIT: begin
          cnt  <= cnt + 16'd1;
          conv <= stat.small_ok;
          j    <= '0;
        end
        ST_EMIT_SHOW: if (out_ready && !j_last) j <= j + 1'b1;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> rtl/lrt_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lrt_dp
// Datapath: stores, multiply-accumulate pipeline, sigmoid lookup, divider
// and weight update arithmetic.
// ----------------------------------------------------------------------------
module lrt_dp (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire lrt_pkg::cfg_t      cfg,
  input  wire lrt_pkg::ctrl_cmd_t cmd,
  input  wire logic [1:0]         ld_code,
  input  wire logic [7:0]         ld_obs,
  input  wire logic [3:0]         ld_feat,
  input  wire logic signed [31:0] ld_value,
  output lrt_pkg::dp_stat_t       stat,
  output logic signed [31:0]      w_rd
);
  import lrt_pkg::*;

  logic signed [31:0] weights      [MaxFeatures];
  logic signed [31:0] next_weights [MaxFeatures];
  logic signed [31:0] feature_mem  [MaxObservations * MaxFeatures];
  logic               label_mem    [MaxObservations];
  logic signed [ERR_W-1:0] err_mem [MaxObservations];

  // stage 1: store reads
  logic                    s1v, s1_b, s1_first, s1_last;
  logic [OBS_W-1:0]        s1_obs;
  logic signed [31:0]      feat_rd;
  logic signed [ERR_W-1:0] err_rd;
  logic                    lab_rd;
  // stage 2: product
  logic                    s2v, s2_b, s2_first, s2_last, s2_lab;
  logic [OBS_W-1:0]        s2_obs;
  logic signed [63:0]      s2_prod;
  logic signed [31:0]      mul_a;
  // stage 3: accumulate
  logic                    s3v, s3_b, s3_last, s3_lab;
  logic [OBS_W-1:0]        s3_obs;
  logic signed [63:0]      acc;
  logic signed [63:0]      term;
  // stage 4: sigmoid index
  logic                    s4v, s4_lab;
  logic [OBS_W-1:0]        s4_obs;
  logic [SIG_W-1:0]        s4_idx;
  logic signed [63:0]      off;
  logic [SIG_W-1:0]        idx_calc;
  logic signed [ERR_W-1:0] err_val;
  // divider and update
  logic                    div_busy;
  logic [DCNT_W-1:0]       dcnt;
  logic [63:0]             dq;
  logic [9:0]              drem;
  logic [9:0]              rs;
  logic                    dneg;
  logic signed [63:0]      qs;
  logic [47:0]             p_lo;
  logic signed [48:0]      p_hi;
  logic signed [63:0]      delta;
  logic signed [63:0]      wide;
  logic signed [31:0]      nw;
  logic signed [31:0]      nw_sat;
  logic signed [32:0]      diff;
  logic [32:0]             diff_abs;
  logic                    small_ok;

  assign stat.busy     = s1v || s2v || s3v || s4v;
  assign stat.div_busy = div_busy;
  assign stat.small_ok = small_ok;

  // loads and stage 1
  always_ff @(posedge clk) begin
    if (cmd.ld_en) begin
      case (cmd_code_t'(ld_code))
        CMD_LOAD_FEATURE: feature_mem[{ld_obs, ld_feat}] <= ld_value;
        CMD_LOAD_LABEL:   label_mem[ld_obs] <= (ld_value != 32'sd0);
        default: ;
      endcase
    end
    feat_rd <= feature_mem[{cmd.obs, cmd.feat}];
    lab_rd  <= label_mem[cmd.obs];
    err_rd  <= err_mem[cmd.obs];
    if (s4v) err_mem[s4_obs] <= err_val;
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_en && cmd_code_t'(ld_code) == CMD_LOAD_WEIGHT) begin
      weights[ld_feat] <= ld_value;
    end else if (cmd.op == OP_COMMIT) begin
      for (int k = 0; k < MaxFeatures; k++) begin
        if (k < int'(cfg.n_eff)) weights[k] <= next_weights[k];
      end
    end
    w_rd <= weights[cmd.feat];
    if (cmd.op == OP_UPDATE) next_weights[cmd.feat] <= nw_sat;
  end

  assign mul_a = s1_b ? 32'(err_rd) : w_rd;
  assign term  = s2_b ? s2_prod : (s2_prod >>> 16);

  always_comb begin
    off = acc + 64'sd524288;
    if (off <= 64'sd0)                                 idx_calc = '0;
    else if ((off >>> SIG_IDX_SHIFT) > 64'(SigDepth - 1)) idx_calc = SIG_W'(SigDepth - 1);
    else                                               idx_calc = off[SIG_IDX_SHIFT +: SIG_W];
  end

  assign err_val = $signed({1'b0, SIG_TABLE[s4_idx]}) - (s4_lab ? 18'sd65536 : 18'sd0);

  always_ff @(posedge clk) begin
    s1_b     <= cmd.phase_b;
    s1_first <= cmd.first;
    s1_last  <= cmd.last;
    s1_obs   <= cmd.obs;
    s2_b     <= s1_b;
    s2_first <= s1_first;
    s2_last  <= s1_last;
    s2_lab   <= lab_rd;
    s2_obs   <= s1_obs;
    s2_prod  <= mul_a * feat_rd;
    s3_b     <= s2_b;
    s3_last  <= s2_last;
    s3_lab   <= s2_lab;
    s3_obs   <= s2_obs;
    if (s2v) acc <= s2_first ? term : acc + term;
    s4_lab   <= s3_lab;
    s4_obs   <= s3_obs;
    s4_idx   <= idx_calc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1v <= 1'b0;
      s2v <= 1'b0;
      s3v <= 1'b0;
      s4v <= 1'b0;
    end else begin
      s1v <= cmd.issue;
      s2v <= s1v;
      s3v <= s2v;
      s4v <= s3v && s3_last && !s3_b;
    end
  end

  // restoring divider, one quotient bit a cycle
  assign rs = {drem[8:0], dq[63]};

  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
      dcnt     <= '0;
    end else if (cmd.op == OP_DIV) begin
      div_busy <= 1'b1;
      dcnt     <= DCNT_W'(DivSteps);
    end else if (div_busy) begin
      dcnt <= dcnt - 1'b1;
      if (dcnt == DCNT_W'(1)) div_busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_DIV) begin
      dneg <= acc[63];
      dq   <= acc[63] ? 64'(-acc) : 64'(acc);
      drem <= '0;
    end else if (div_busy) begin
      if (rs >= {1'b0, cfg.m_eff}) begin
        drem <= rs - {1'b0, cfg.m_eff};
        dq   <= {dq[62:0], 1'b1};
      end else begin
        drem <= rs;
        dq   <= {dq[62:0], 1'b0};
      end
    end
  end

  always_comb begin
    wide = {{32{w_rd[31]}}, w_rd} - delta;
    if (wide > 64'sd2147483647)       nw_sat = 32'sh7fffffff;
    else if (wide < -64'sd2147483648) nw_sat = 32'sh80000000;
    else                              nw_sat = wide[31:0];
    diff     = {nw[31], nw} - {w_rd[31], w_rd};
    diff_abs = diff[32] ? 33'(-diff) : 33'(diff);
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_SIGN:   qs    <= dneg ? -$signed(dq) : $signed(dq);
      OP_MUL_LO: p_lo  <= qs[31:0] * cfg.lr;
      OP_MUL_HI: p_hi  <= $signed(qs[63:32]) * $signed({1'b0, cfg.lr});
      OP_DELTA:  delta <= {{15{p_hi[48]}}, p_hi} + $signed({48'd0, p_lo[47:32]});
      OP_UPDATE: nw    <= nw_sat;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      small_ok <= 1'b0;
    end else if (cmd.op == OP_CLEAR) begin
      small_ok <= 1'b1;
    end else if (cmd.op == OP_CHECK && diff_abs > {17'd0, cfg.tol}) begin
      small_ok <= 1'b0;
    end
  end

endmodule
`default_nettype wire

>>> rtl/logistic_regression_trainer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// logistic_regression_trainer
// Batch gradient descent trainer for logistic regression, Q16.16.
// ----------------------------------------------------------------------------
// din carries load items (weight, feature, label) and the start item; dout
// carries one item per trained weight, index 0 first, last set on the final
// one. Registers should be written over the APB port only while the block
// is idle; the block itself does not enforce this. Load items are taken
// while the block is idle and may follow back to back. A start item holds
// din.ready low until every weight has been handed out. In each step the
// single multiply-accumulate pipeline visits every feature once for the dot
// products and once for the gradients, and each weight then passes through
// the bit-serial divider. Reset returns the registers to their defaults and
// the sequencer to idle; the stores need no clearing. When dout is stalled
// the current weight is held and nothing else moves.
// ----------------------------------------------------------------------------
module logistic_regression_trainer (
  input  wire logic                        clk,
  input  wire logic                        rst,
  lrt_in_if.sink                           din,
  lrt_out_if.source                        dout,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [lrt_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import lrt_pkg::*;

  cfg_t      cfg;
  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  lrt_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  lrt_ctrl u_ctrl (
    .clk, .rst, .cfg,
    .in_valid  (din.valid),
    .in_cmd    (din.cmd),
    .in_ready  (din.ready),
    .out_valid (dout.valid),
    .out_ready (dout.ready),
    .out_index (dout.weight_index),
    .out_conv  (dout.converged),
    .out_iters (dout.iterations_used),
    .out_last  (dout.last),
    .cmd, .stat
  );

  lrt_dp u_dp (
    .clk, .rst, .cfg, .cmd,
    .ld_code  (din.cmd),
    .ld_obs   (din.obs_index),
    .ld_feat  (din.feature_index),
    .ld_value (din.value),
    .stat,
    .w_rd     (dout.weight_value)
  );

endmodule
`default_nettype wire

>>> rtl/lrt_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lrt_checker
// Port-level checks on the trainer, bound to the top level.
// ----------------------------------------------------------------------------
module lrt_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic [1:0]  in_cmd,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_value,
  input wire logic        out_last
);
  import lrt_pkg::*;

  // no input is taken while trained weights are being handed out
  a_no_input_during_emit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input ready while emitting");

  // a start item stalls the input side
  a_start_stalls: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_cmd == CMD_START) |=> !in_ready)
    else $error("input ready right after start");

  // after the final weight the output goes quiet
  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && out_last) |=> !out_valid)
    else $error("output continues after last");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_value)))
    else $error("stalled output changed");

endmodule

bind logistic_regression_trainer lrt_checker u_lrt_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (din.valid),
  .in_ready  (din.ready),
  .in_cmd    (din.cmd),
  .out_valid (dout.valid),
  .out_ready (dout.ready),
  .out_value (dout.weight_value),
  .out_last  (dout.last)
);
`default_nettype wire
